[rtl/core/ecol_pkg.sv]
package ecol_pkg;

    localparam int FRAC_BITS = 16;

    localparam logic [16:0] ONE_Q16      = 17'd65536;
    localparam logic [16:0] HALF_Q16     = 17'd32768;
    localparam logic [14:0] INV_LN10_Q16 = 15'd28462;
    localparam logic [7:0]  CH_MAX       = 8'd255;

    localparam logic CFG_LIMIT = 1'b0;
    localparam logic CFG_MODE  = 1'b1;

    localparam logic [1:0] MODE_STRIPED = 2'd1;
    localparam logic [1:0] MODE_BW      = 2'd2;

    typedef struct packed {
        logic black;
        logic white;
        logic striped;
        logic num_zero;
        logic den_zero;
    } t_side;

    // sin(k*pi/32) in Q16 for k = 0..16
    function automatic logic [16:0] sine_q16(input logic [4:0] k);
        logic [16:0] s;
        case (k)
            5'd0:    s = 17'd0;
            5'd1:    s = 17'd6424;
            5'd2:    s = 17'd12785;
            5'd3:    s = 17'd19024;
            5'd4:    s = 17'd25080;
            5'd5:    s = 17'd30893;
            5'd6:    s = 17'd36410;
            5'd7:    s = 17'd41576;
            5'd8:    s = 17'd46341;
            5'd9:    s = 17'd50660;
            5'd10:   s = 17'd54491;
            5'd11:   s = 17'd57798;
            5'd12:   s = 17'd60547;
            5'd13:   s = 17'd62714;
            5'd14:   s = 17'd64277;
            5'd15:   s = 17'd65220;
            default: s = 17'd65536;
        endcase
        return s;
    endfunction

endpackage

[rtl/core/ecol_log2.sv]
module ecol_log2 #(
    parameter int XW = 17
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [XW-1:0]           i_x,
    output logic [$clog2(XW)+15:0]  o_log
);

    localparam int MSBW = $clog2(XW);
    localparam int FB   = ecol_pkg::FRAC_BITS;

    logic [MSBW-1:0] w_msb;
    logic [4:0]      w_shamt;
    logic [30:0]     w_m0;

    logic [30:0]     r_m   [0:FB];
    logic [MSBW-1:0] r_msb [0:FB];
    logic [FB-1:0]   r_frac[0:FB];

    always_comb begin
        w_msb = '0;
        for (int b = 0; b < XW; b++) begin
            if (i_x[b]) begin
                w_msb = MSBW'(b);
            end
        end
    end

    assign w_shamt = 5'(30 - int'(w_msb));
    assign w_m0    = 31'(i_x) << w_shamt;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0]    <= w_m0;
            r_msb[0]  <= w_msb;
            r_frac[0] <= '0;
        end
    end

    for (genvar i = 1; i <= FB; i++) begin : g_sq
        logic [61:0] w_sq;
        assign w_sq = 62'(r_m[i-1]) * 62'(r_m[i-1]);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[i]    <= w_sq[61] ? w_sq[61:31] : w_sq[60:30];
                r_msb[i]  <= r_msb[i-1];
                r_frac[i] <= {r_frac[i-1][FB-2:0], w_sq[61]};
            end
        end
    end

    assign o_log = {r_msb[FB], r_frac[FB]};

endmodule

[rtl/core/ecol_div.sv]
module ecol_div #(
    parameter int LOGW = 21
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [LOGW-1:0] i_num,
    input  logic [LOGW-1:0] i_den,
    output logic [LOGW-1:0] o_q
);

    localparam int RW = LOGW + 16;
    localparam int CW = 2 * LOGW;

    logic [RW-1:0]   r_rem[0:LOGW-2];
    logic [LOGW-1:0] r_den[0:LOGW-2];
    logic [LOGW-1:0] r_q  [0:LOGW-1];

    for (genvar s = 0; s < LOGW; s++) begin : g_step
        logic [RW-1:0]   w_rem_in;
        logic [LOGW-1:0] w_den_in;
        logic [LOGW-1:0] w_q_in;
        logic [CW-1:0]   w_dsh;
        logic            w_ge;

        if (s == 0) begin : g_first
            assign w_rem_in = RW'(i_num) << 16;
            assign w_den_in = i_den;
            assign w_q_in   = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[s-1];
            assign w_den_in = r_den[s-1];
            assign w_q_in   = r_q[s-1];
        end

        assign w_dsh = CW'(w_den_in) << (LOGW - 1 - s);
        assign w_ge  = CW'(w_rem_in) >= w_dsh;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[s] <= {w_q_in[LOGW-2:0], w_ge};
            end
        end

        if (s < LOGW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= w_ge ? (w_rem_in - w_dsh[RW-1:0]) : w_rem_in;
                    r_den[s] <= w_den_in;
                end
            end
        end
    end

    assign o_q = r_q[LOGW-1];

endmodule

[rtl/core/ecol_shade.sv]
module ecol_shade #(
    parameter int QW = 21
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [QW-1:0]       i_q,
    input  ecol_pkg::t_side     i_side,
    output logic [7:0]          o_red,
    output logic [7:0]          o_green,
    output logic [7:0]          o_blue
);

    localparam int PW = QW + 15;

    // ratio and striped scaling
    logic [QW-1:0]   w_ratio;
    logic [PW-1:0]   w_prod;
    logic [QW-1:0]   r1_ratio;
    logic [PW-1:0]   r1_prod;
    ecol_pkg::t_side r1_side;

    assign w_ratio = i_side.num_zero ? '0 :
                     i_side.den_zero ? QW'(ecol_pkg::ONE_Q16) : i_q;
    assign w_prod  = PW'(w_ratio) * PW'(ecol_pkg::INV_LN10_Q16);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ratio <= w_ratio;
            r1_prod  <= w_prod;
            r1_side  <= i_side;
        end
    end

    // saturate t at 1.0
    logic [QW-1:0]   w_sel;
    logic [16:0]     r2_t;
    logic            r2_black;
    logic            r2_white;

    assign w_sel = r1_side.striped ? QW'(r1_prod[PW-1:16]) : r1_ratio;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_t     <= (w_sel > QW'(ecol_pkg::ONE_Q16)) ? ecol_pkg::ONE_Q16 : w_sel[16:0];
            r2_black <= r1_side.black;
            r2_white <= r1_side.white;
        end
    end

    // t squared and sine
    logic [33:0] w_t2;
    logic [15:0] w_u;
    logic [4:0]  w_k;
    logic [16:0] w_base;
    logic [16:0] w_diff;
    logic [27:0] w_interp;
    logic [16:0] w_s;
    logic [16:0] r3_t;
    logic [32:0] r3_t2;
    logic [16:0] r3_s;
    logic        r3_black;
    logic        r3_white;

    assign w_t2     = 34'(r2_t) * 34'(r2_t);
    assign w_u      = (r2_t <= ecol_pkg::HALF_Q16) ? r2_t[15:0] :
                      16'(ecol_pkg::ONE_Q16 - r2_t);
    assign w_k      = w_u[15:11];
    assign w_base   = ecol_pkg::sine_q16(w_k);
    assign w_diff   = ecol_pkg::sine_q16(w_k + 5'd1) - w_base;
    assign w_interp = 28'(w_diff) * 28'(w_u[10:0]);
    assign w_s      = (w_k >= 5'd16) ? ecol_pkg::ONE_Q16 : (w_base + w_interp[27:11]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_t     <= r2_t;
            r3_t2    <= w_t2[32:0];
            r3_s     <= w_s;
            r3_black <= r2_black;
            r3_white <= r2_white;
        end
    end

    // t cubed, red and blue
    logic [33:0] w_ta;
    logic [32:0] w_tb;
    logic [40:0] w_r41;
    logic [24:0] w_b25;
    logic [33:0] r4_t3;
    logic [7:0]  r4_red;
    logic [7:0]  r4_blue;
    logic        r4_black;
    logic        r4_white;

    assign w_ta  = 34'(r3_t2[32:16]) * 34'(r3_t);
    assign w_tb  = 33'(r3_t2[15:0]) * 33'(r3_t);
    assign w_r41 = (41'(r3_t2) << 8) - 41'(r3_t2);
    assign w_b25 = (25'(r3_s) << 8) - 25'(r3_s);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_t3    <= w_ta + 34'(w_tb[32:16]);
            r4_red   <= w_r41[40] ? ecol_pkg::CH_MAX : w_r41[39:32];
            r4_blue  <= w_b25[24] ? ecol_pkg::CH_MAX : w_b25[23:16];
            r4_black <= r3_black;
            r4_white <= r3_white;
        end
    end

    // green and final colour select
    logic [41:0] w_g42;
    logic [7:0]  w_green;
    logic [7:0]  r5_red;
    logic [7:0]  r5_green;
    logic [7:0]  r5_blue;

    assign w_g42   = (42'(r4_t3) << 8) - 42'(r4_t3);
    assign w_green = (w_g42[41:40] != 2'b00) ? ecol_pkg::CH_MAX : w_g42[39:32];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r4_black) begin
                r5_red   <= '0;
                r5_green <= '0;
                r5_blue  <= '0;
            end else if (r4_white) begin
                r5_red   <= ecol_pkg::CH_MAX;
                r5_green <= ecol_pkg::CH_MAX;
                r5_blue  <= ecol_pkg::CH_MAX;
            end else begin
                r5_red   <= r4_red;
                r5_green <= w_green;
                r5_blue  <= r4_blue;
            end
        end
    end

    assign o_red   = r5_red;
    assign o_green = r5_green;
    assign o_blue  = r5_blue;

endmodule

[rtl/core/escape_iteration_colorizer.sv]
// The pipeline has an input register, two parallel log2 lanes of 16 squaring stages,
// one stage per quotient bit in the divider and five colour stages.
// Throughput: one pixel per cycle; a stall at the output holds every stage.
// Reset clears all valid bits, sets the iteration limit to 256 and the mode to smooth.
module escape_iteration_colorizer #(
    parameter int ITER_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_iteration_count,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    localparam int XW      = ITER_BITS + 1;
    localparam int LOGW    = $clog2(XW) + 16;
    localparam int LOG_LAT = ecol_pkg::FRAC_BITS + 1;
    localparam int SD      = LOG_LAT + LOGW;
    localparam int TOT     = 1 + SD + 5;

    logic [ITER_BITS-1:0] r_limit;
    logic [1:0]           r_mode;
    logic [ITER_BITS-1:0] r_cnt;
    logic [TOT-1:0]       r_vld;
    ecol_pkg::t_side      r_side[0:SD-1];

    logic                 w_en;
    logic [XW-1:0]        w_x;
    logic [LOGW-1:0]      w_num;
    logic [LOGW-1:0]      w_den;
    logic [LOGW-1:0]      w_q;
    ecol_pkg::t_side      w_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= ITER_BITS'(256);
            r_mode  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ecol_pkg::CFG_LIMIT: r_limit <= ITER_BITS'(i_cfg_data);
                ecol_pkg::CFG_MODE:  r_mode  <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    assign w_en    = !(r_vld[TOT-1] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[TOT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[TOT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cnt <= ITER_BITS'(i_iteration_count);
        end
    end

    assign w_x = XW'(r_cnt) + XW'(1);

    assign w_side.black    = r_cnt == r_limit;
    assign w_side.white    = r_mode == ecol_pkg::MODE_BW;
    assign w_side.striped  = (r_mode == ecol_pkg::MODE_STRIPED) && r_cnt[0];
    assign w_side.num_zero = r_cnt == '0;
    assign w_side.den_zero = r_limit <= ITER_BITS'(1);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= w_side;
            for (int j = 1; j < SD; j++) begin
                r_side[j] <= r_side[j-1];
            end
        end
    end

    ecol_log2 #(.XW(XW)) u_log_num (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (w_x),
        .o_log (w_num)
    );

    ecol_log2 #(.XW(XW)) u_log_den (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (XW'(r_limit)),
        .o_log (w_den)
    );

    ecol_div #(.LOGW(LOGW)) u_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (w_num),
        .i_den (w_den),
        .o_q   (w_q)
    );

    ecol_shade #(.QW(LOGW)) u_shade (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_q     (w_q),
        .i_side  (r_side[SD-1]),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue)
    );

endmodule

[tb/escape_iteration_colorizer_test.sv]
module escape_iteration_colorizer_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 44;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [15:0] i_iteration_count;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [15:0] i_cfg_data;

    escape_iteration_colorizer dut (.*);

    logic [15:0] pending_counts[$];
    t_pixel      expected_pixels[$];
    logic [15:0] cur_limit;
    logic [1:0]  cur_mode;
    logic        in_taken;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_off;
    int          mismatches;
    int          pixels_checked;
    int          counts_sent;

    localparam logic [16:0] SINE_LUT [17] = '{
        17'd0, 17'd6424, 17'd12785, 17'd19024, 17'd25080, 17'd30893, 17'd36410,
        17'd41576, 17'd46341, 17'd50660, 17'd54491, 17'd57798, 17'd60547,
        17'd62714, 17'd64277, 17'd65220, 17'd65536
    };

    function automatic logic [63:0] log2_fixed(input logic [31:0] x);
        int          lead;
        logic [63:0] mant;
        logic [15:0] frac;
        lead = 0;
        frac = '0;
        if (x == 0)
            return 64'd0;
        for (int b = 0; b < 32; b++)
            if (x[b])
                lead = b;
        mant = 64'(x) << (30 - lead);
        for (int i = 0; i < 16; i++) begin
            mant = (mant * mant) >> 30;
            frac = frac << 1;
            if (mant >= (64'd2 << 30)) begin
                frac[0] = 1'b1;
                mant = mant >> 1;
            end
        end
        return (64'(lead) << 16) | 64'(frac);
    endfunction

    function automatic t_pixel colour_of(input logic [15:0] count,
                                         input logic [15:0] limit,
                                         input logic [1:0] mode);
        logic [63:0] num, den, ratio, t, t2, t3, r, g, b, u, k, f, s;
        t_pixel      px;
        if (count == limit)
            return '{8'd0, 8'd0, 8'd0};
        if (mode == ecol_pkg::MODE_BW)
            return '{ecol_pkg::CH_MAX, ecol_pkg::CH_MAX, ecol_pkg::CH_MAX};
        num = log2_fixed(32'(count) + 1);
        den = log2_fixed(32'(limit));
        if (num == 0)
            ratio = 0;
        else if (den == 0)
            ratio = 65536;
        else
            ratio = (num << 16) / den;
        if (mode == ecol_pkg::MODE_STRIPED && count[0])
            ratio = (ratio * 28462) >> 16;
        t = (ratio > 65536) ? 64'd65536 : ratio;
        t2 = t * t;
        t3 = (t2 >> 16) * t + (((t2 & 64'hFFFF) * t) >> 16);
        r = (255 * t2) >> 32;
        g = (255 * t3) >> 32;
        u = (t <= 32768) ? t : 65536 - t;
        k = u >> 11;
        f = u & 2047;
        if (k >= 16)
            s = SINE_LUT[16];
        else
            s = SINE_LUT[k] + (((SINE_LUT[k + 1] - SINE_LUT[k]) * f) >> 11);
        b = (255 * s) >> 16;
        px.red   = (r > 255) ? ecol_pkg::CH_MAX : r[7:0];
        px.green = (g > 255) ? ecol_pkg::CH_MAX : g[7:0];
        px.blue  = (b > 255) ? ecol_pkg::CH_MAX : b[7:0];
        return px;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #100ms;
        $display("Mismatches found");
        $finish;
    end

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !in_taken) begin
        end else if (pending_counts.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            i_valid <= 1'b1;
            i_iteration_count <= pending_counts.pop_front();
        end else begin
            i_valid <= 1'b0;
            i_iteration_count <= 16'($urandom);
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            i_stall <= 1'b1;
            hold_off <= hold_off - 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_pixel want;
        in_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) begin
            expected_pixels.push_back(colour_of(i_iteration_count, cur_limit, cur_mode));
            counts_sent <= counts_sent + 1;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            pixels_checked <= pixels_checked + 1;
            if (expected_pixels.size() == 0) begin
                $error("unexpected pixel %0d %0d %0d", o_red, o_green, o_blue);
                mismatches++;
            end else begin
                want = expected_pixels.pop_front();
                if (o_red !== want.red) begin
                    $error("red expected %0d actual %0d", want.red, o_red);
                    mismatches++;
                end
                if (o_green !== want.green) begin
                    $error("green expected %0d actual %0d", want.green, o_green);
                    mismatches++;
                end
                if (o_blue !== want.blue) begin
                    $error("blue expected %0d actual %0d", want.blue, o_blue);
                    mismatches++;
                end
            end
        end
    end

    task automatic drain();
        while (pending_counts.size() > 0 || expected_pixels.size() > 0 || i_valid)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == ecol_pkg::CFG_LIMIT)
            cur_limit = value;
        else
            cur_mode = value[1:0];
    endtask

    function automatic logic [15:0] random_count(input logic [15:0] limit);
        case ($urandom_range(9))
            0: return limit;
            1: return limit + 16'($urandom_range(3));
            2: return 16'($urandom);
            3: return 16'($urandom_range(7));
            default: return 16'($urandom_range(32'(limit)));
        endcase
    endfunction

    initial begin
        logic [15:0] limits[6];
        int          phase;
        limits = '{16'd256, 16'd2, 16'd65535, 16'd1000, 16'd17, 16'd0};
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_iteration_count = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = ecol_pkg::CFG_LIMIT;
        i_cfg_data = '0;
        cur_limit = 16'd256;
        cur_mode = 2'd0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 0;
        mismatches = 0;
        pixels_checked = 0;
        counts_sent = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset settings, extremes, then every mode
        foreach (limits[n])
            ;
        pending_counts = '{16'd0, 16'd1, 16'd2, 16'd255, 16'd256, 16'd257, 16'd65535,
                           16'd128, 16'd127, 16'hAAAA, 16'h5555};
        drain();
        for (int m = 0; m < 4; m++) begin
            write_reg(ecol_pkg::CFG_MODE, 16'(m));
            write_reg(ecol_pkg::CFG_LIMIT, (m == 3) ? 16'd1 : 16'd65535);
            pending_counts = '{16'd0, 16'd1, 16'd3, cur_limit, 16'd65534};
            drain();
        end

        // random phases, one limit and mode per phase
        for (phase = 0; phase < 12; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            write_reg(ecol_pkg::CFG_LIMIT,
                      (phase < 6) ? limits[phase] : 16'($urandom_range(65535, 2)));
            write_reg(ecol_pkg::CFG_MODE, 16'(phase % 3));
            if (phase == 4)
                hold_off = 300;
            repeat (125) pending_counts.push_back(random_count(cur_limit));
            drain();
        end

        $display("Checked %0d pixels over %0d transfers across limits 0..65535 and all modes",
                 pixels_checked, counts_sent);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
